// File: sv/iou_gated_match_cost_top_assert.svh
// Assertion macros shared by the gated IoU cost block.
`ifndef IOU_GATED_MATCH_COST_TOP_ASSERT_SVH
`define IOU_GATED_MATCH_COST_TOP_ASSERT_SVH

// Implication checked in the same cycle, sampled on clk, off during reset.
`define IOUGM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iou cost check failed");

// Implication checked in the following cycle, sampled on clk, off during reset.
`define IOUGM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iou cost check failed");

`endif

// File: sv/iougm_pkg.sv
// Package with widths, word types and constants of the gated IoU cost block.
`default_nettype none
package iougm_pkg;

  localparam int COST_FRAC_BITS = 16;

  localparam int COORD_W   = 16;
  localparam int SIZE_W    = 15;
  localparam int FRAMES_W  = 8;
  localparam int COST_W    = 24;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int AREA_W    = 2 * SIZE_W;
  localparam int SUM_W     = AREA_W + 1;
  localparam int QUO_W     = COST_FRAC_BITS + 1;

  localparam int GEOM_STAGES = 4;
  localparam int NUM_STAGES  = GEOM_STAGES + COST_FRAC_BITS + 1;

  localparam int IN_BITS     = 6 * COORD_W / 1 - 2 * COORD_W + 4 * SIZE_W + FRAMES_W;
  localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((COST_W + 7) / 8) * 8;

  localparam logic [COST_W-1:0] COST_ONE      = COST_W'(1 << COST_FRAC_BITS);
  localparam logic [COST_W-1:0] INF_COST_INIT = {COST_W{1'b1}};

  typedef struct packed {
    logic [COORD_W-1:0]  track_left;
    logic [COORD_W-1:0]  track_top;
    logic [SIZE_W-1:0]   track_width;
    logic [SIZE_W-1:0]   track_height;
    logic [COORD_W-1:0]  det_left;
    logic [COORD_W-1:0]  det_top;
    logic [SIZE_W-1:0]   det_width;
    logic [SIZE_W-1:0]   det_height;
    logic [FRAMES_W-1:0] frames_since_update;
  } box_pair_t;

  // One word in flight through the divider.
  typedef struct packed {
    logic [SUM_W-1:0] uni;
    logic [SUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             gated;
    logic             uzero;
  } div_word_t;

endpackage
`default_nettype wire

// File: sv/iou_gated_match_cost_top.sv
// Top level of the gated intersection-over-union match cost pipeline.
//
// Each input word on the s_axis channel carries one track box and one
// detection box (top-left corner plus size, signed Q12.4 pixels) and the
// number of frames since the track was last matched. For each input word the
// block returns one output word on m_axis holding the match cost: the
// configured infinite cost when the track missed more than one frame,
// otherwise one minus intersection over union as an unsigned fraction with
// COST_FRAC_BITS fractional bits, truncated. Two empty boxes give exactly 1.0.
// The pipeline has 4 geometry stages, one restoring divider stage per
// fractional bit and an output register: 21 register stages in all. The first
// stage loads at the edge that accepts the input word, and the word passes on
// through the geometry, divider and output stages in order to m_axis. One word
// is accepted and one delivered every cycle while the receiver keeps up.
// When the receiver stalls, words collapse into empty stages ahead of the
// output, so input is still taken until every stage is full; nothing is lost
// or repeated. Reset empties the pipeline and sets the infinite cost to its
// all-ones value. The user writes the infinite cost register through cfg_wen
// and cfg_wdata only while the block is idle; the block does not enforce it.
`default_nettype none
module iou_gated_match_cost_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wen,
  input  wire logic [iougm_pkg::COST_W-1:0]    cfg_wdata,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0 up: track_left, track_top, track_width, track_height,
  // det_left, det_top, det_width, det_height, frames_since_update, zero pad.
  input  wire logic [iougm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // Fields from bit 0 up: match_cost.
  output logic [iougm_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
  import iougm_pkg::*;

  localparam int OUT_STG = NUM_STAGES - 1;

  logic [COST_W-1:0]     infinite_cost;
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_next;
  // adv[k] is high when stage k may load: it is empty or its word moves on.
  logic [NUM_STAGES:0]   adv;
  box_pair_t             box;
  div_word_t             dw [COST_FRAC_BITS+1];
  logic [COST_W-1:0]     out_cost;
  logic                  out_gated;

  // Unpack the input word, lowest field in the lowest bits.
  always_comb begin
    box.track_left          = s_axis_tdata[15:0];
    box.track_top           = s_axis_tdata[31:16];
    box.track_width         = s_axis_tdata[46:32];
    box.track_height        = s_axis_tdata[61:47];
    box.det_left            = s_axis_tdata[77:62];
    box.det_top             = s_axis_tdata[93:78];
    box.det_width           = s_axis_tdata[108:94];
    box.det_height          = s_axis_tdata[123:109];
    box.frames_since_update = s_axis_tdata[131:124];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      infinite_cost <= INF_COST_INIT;
    end else if (cfg_wen) begin
      infinite_cost <= cfg_wdata;
    end
  end

  // Backward ready chain: a stage loads when it is free or drains forward.
  assign adv[NUM_STAGES] = m_axis_tready;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_adv
    assign adv[k] = ~vld[k] | adv[k+1];
  end

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        vld_next[k] = (k == 0) ? s_axis_tvalid : vld[(k == 0) ? 0 : k - 1];
      end else begin
        vld_next[k] = vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  iougm_geom u_geom (
    .clk (clk),
    .en  (adv[GEOM_STAGES-1:0]),
    .box (box),
    .out (dw[0])
  );

  // One quotient bit per stage.
  for (genvar i = 0; i < COST_FRAC_BITS; i++) begin : g_div
    iougm_div_step u_step (
      .clk (clk),
      .en  (adv[GEOM_STAGES+i]),
      .d   (dw[i]),
      .q   (dw[i+1])
    );
  end

  // Output register: gating and the empty-union case override the quotient.
  always_ff @(posedge clk) begin
    if (adv[OUT_STG]) begin
      out_gated <= dw[COST_FRAC_BITS].gated;
      if (dw[COST_FRAC_BITS].gated) begin
        out_cost <= infinite_cost;
      end else if (dw[COST_FRAC_BITS].uzero) begin
        out_cost <= COST_ONE;
      end else begin
        out_cost <= {{(COST_W-QUO_W){1'b0}}, dw[COST_FRAC_BITS].quo};
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[OUT_STG];
  assign m_axis_tdata  = M_TDATA_W'(out_cost);

`include "iou_gated_match_cost_top_assert.svh"

  // An ungated cost never exceeds 1.0.
  `IOUGM_ASSERT_SAME(a_cost_le_one, m_axis_tvalid && !out_gated, out_cost <= COST_ONE)
  // With the output stage empty the whole pipeline can take a word.
  `IOUGM_ASSERT_SAME(a_ready_when_drained, !m_axis_tvalid, s_axis_tready)
  // The divider remainder stays below the union.
  `IOUGM_ASSERT_SAME(a_rem_below_union,
    vld[OUT_STG-1] && !dw[COST_FRAC_BITS].uzero,
    dw[COST_FRAC_BITS].rem < dw[COST_FRAC_BITS].uni)
  // A word that leaves the last divider stage is in the output register next.
  `IOUGM_ASSERT_NEXT(a_out_fill, vld[OUT_STG-1] && adv[OUT_STG], m_axis_tvalid)

endmodule
`default_nettype wire

// File: sv/iougm_geom.sv
// Box geometry stages: edges, clipped intersection, areas and union.
`default_nettype none
module iougm_geom (
  input  wire logic                              clk,
  input  wire logic [iougm_pkg::GEOM_STAGES-1:0] en,
  input  wire iougm_pkg::box_pair_t              box,
  output iougm_pkg::div_word_t                   out
);
  import iougm_pkg::*;

  // Stage 1: right and bottom edges, larger left and top.
  logic [EDGE_W-1:0]  tr, tb, dr, db;
  logic [COORD_W-1:0] xl, yt;
  logic [SIZE_W-1:0]  tw1, th1, dw1, dh1;
  logic               g1;

  // Stage 2: clipped intersection size and box areas.
  logic [SIZE_W-1:0]  iw, ih;
  logic [AREA_W-1:0]  at2, ad2;
  logic               g2;

  // Stage 3: intersection area and area sum.
  logic [AREA_W-1:0]  inter;
  logic [SUM_W-1:0]   asum;
  logic               g3;

  logic [EDGE_W-1:0]  rmin, bmin;
  logic [EDGE_W:0]    dx, dy;
  logic [SUM_W-1:0]   uni, num;
  logic               izero;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tr  <= {box.track_left[COORD_W-1], box.track_left} + {2'b00, box.track_width};
      tb  <= {box.track_top[COORD_W-1], box.track_top} + {2'b00, box.track_height};
      dr  <= {box.det_left[COORD_W-1], box.det_left} + {2'b00, box.det_width};
      db  <= {box.det_top[COORD_W-1], box.det_top} + {2'b00, box.det_height};
      xl  <= ($signed(box.track_left) > $signed(box.det_left)) ? box.track_left
                                                                : box.det_left;
      yt  <= ($signed(box.track_top) > $signed(box.det_top)) ? box.track_top
                                                              : box.det_top;
      tw1 <= box.track_width;
      th1 <= box.track_height;
      dw1 <= box.det_width;
      dh1 <= box.det_height;
      g1  <= (box.frames_since_update[FRAMES_W-1:1] != '0);
    end
  end

  always_comb begin
    rmin = ($signed(tr) < $signed(dr)) ? tr : dr;
    bmin = ($signed(tb) < $signed(db)) ? tb : db;
    dx   = {rmin[EDGE_W-1], rmin} - {{2{xl[COORD_W-1]}}, xl};
    dy   = {bmin[EDGE_W-1], bmin} - {{2{yt[COORD_W-1]}}, yt};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      // The overlap never exceeds either box size, so 15 bits hold it.
      iw  <= dx[EDGE_W] ? '0 : dx[SIZE_W-1:0];
      ih  <= dy[EDGE_W] ? '0 : dy[SIZE_W-1:0];
      at2 <= {{SIZE_W{1'b0}}, tw1} * {{SIZE_W{1'b0}}, th1};
      ad2 <= {{SIZE_W{1'b0}}, dw1} * {{SIZE_W{1'b0}}, dh1};
      g2  <= g1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      inter <= {{SIZE_W{1'b0}}, iw} * {{SIZE_W{1'b0}}, ih};
      asum  <= {1'b0, at2} + {1'b0, ad2};
      g3    <= g2;
    end
  end

  always_comb begin
    uni   = asum - {1'b0, inter};
    num   = asum - {inter, 1'b0};
    izero = (inter == '0);
  end

  // Stage 4: the integer quotient bit is one exactly when nothing overlaps.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      out.uni   <= uni;
      out.rem   <= izero ? '0 : num;
      out.quo   <= {{COST_FRAC_BITS{1'b0}}, izero};
      out.gated <= g3;
      out.uzero <= (asum == '0);
    end
  end

endmodule
`default_nettype wire

// File: sv/iougm_div_step.sv
// One restoring division step producing one fractional cost bit.
`default_nettype none
module iougm_div_step (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire iougm_pkg::div_word_t d,
  output iougm_pkg::div_word_t      q
);
  import iougm_pkg::*;

  logic [SUM_W:0] r2;
  logic [SUM_W:0] diff;
  logic           ge;

  always_comb begin
    r2   = {d.rem, 1'b0};
    diff = r2 - {1'b0, d.uni};
    ge   = (r2 >= {1'b0, d.uni});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.uni   <= d.uni;
      q.rem   <= ge ? diff[SUM_W-1:0] : r2[SUM_W-1:0];
      q.quo   <= {d.quo[QUO_W-2:0], ge};
      q.gated <= d.gated;
      q.uzero <= d.uzero;
    end
  end

endmodule
`default_nettype wire
